// File: rtl/fwf_pkg.sv
package fwf_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int IDX_W = $clog2(PATTERN_MAX);
	localparam int LEN_W = 7;
	localparam int CNT_W = $clog2(PATTERN_MAX + 1);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_QUES = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_NAME = 1'b1;

	localparam logic REG_INCLUDE_MODE = 1'b0;
	localparam logic REG_PATTERN_LENGTH = 1'b1;

	// wave that walks down the cell row, one cell per cycle
	typedef struct packed {
		logic       valid;
		logic       eval_empty;
		logic       at_start;
		logic       want_hit;
		logic [7:0] ch;
		logic       left_space;
		logic       empty_left;
		logic       prev_left;
		logic       new_left;
		logic       hit;
	} wave_t;

	typedef struct packed {
		logic wr_en;
		logic in_len;
		logic last_pos;
	} cell_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

// File: rtl/fwf_cell.sv
module fwf_cell import fwf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic [7:0] wr_data,
	input  logic       right_space,
	input  wave_t      tok_in,
	output wave_t      tok_out,
	output logic       is_space
);

	logic [7:0] pat_q;
	logic [7:0] pat_f;
	logic       row_q;
	logic       is_star;
	logic       is_ques;
	logic       ts;
	logic       empty_j;
	logic       prev_j;
	logic       prev_left;
	logic       new_left;
	logic       next_j;
	logic       row_val;
	logic       closes;
	wave_t      tok_d;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			pat_q <= wr_data;
		end
	end

	assign is_space = (pat_q == CH_SPACE);

	always_comb begin
		pat_f   = fold_byte(pat_q);
		is_star = (pat_q == CH_STAR);
		is_ques = (pat_q == CH_QUES);
		ts      = tok_in.left_space;
		// row bit for an empty base name: a run of stars from the token start
		empty_j   = ctl.in_len && is_star && (ts || tok_in.empty_left);
		prev_j    = tok_in.at_start ? empty_j : row_q;
		prev_left = ts ? tok_in.at_start : tok_in.prev_left;
		new_left  = ts ? 1'b0 : tok_in.new_left;
		if (!ctl.in_len || is_space) begin
			next_j = 1'b0;
		end else if (is_star) begin
			next_j = new_left || prev_j;
		end else if (is_ques || pat_f == tok_in.ch) begin
			next_j = prev_left;
		end else begin
			next_j = 1'b0;
		end
		row_val = tok_in.eval_empty ? empty_j : next_j;
		closes  = ctl.last_pos || right_space;

		tok_d            = tok_in;
		tok_d.left_space = is_space;
		tok_d.empty_left = empty_j;
		tok_d.prev_left  = prev_j;
		tok_d.new_left   = next_j;
		tok_d.hit        = tok_in.hit || (ctl.in_len && !is_space && closes && row_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
			row_q   <= 1'b0;
		end else begin
			tok_out <= tok_d;
			if (tok_in.valid && !tok_in.eval_empty) begin
				row_q <= next_j;
			end
		end
	end

endmodule

// File: rtl/fwf_apb.sv
module fwf_apb import fwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic              include_mode,
	output logic [LEN_W-1:0]  pattern_length
);

	logic include_mode_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic reg_idx;
	logic wr;

	assign reg_idx = paddr[2];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_mode_q   <= 1'b1;
			pattern_length_q <= '0;
		end else if (wr) begin
			case (reg_idx)
				REG_INCLUDE_MODE: include_mode_q <= pwdata[0];
				REG_PATTERN_LENGTH: pattern_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INCLUDE_MODE: prdata = DATA_W'(include_mode_q);
			REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length_q);
			default: prdata = '0;
		endcase
	end

	assign include_mode   = include_mode_q;
	assign pattern_length = pattern_length_q;

endmodule

// File: rtl/filename_wildcard_filter.sv
// Filename wildcard filter.
// Input channel item_valid/item_ready: func 0 writes byte_value into the pattern
// store at pattern_index; func 1 streams one filename byte, with name_last on
// the final byte. A '/' or '\' that is not the last byte only marks a new base
// name start and leaves the input open. Every other filename byte sends a wave
// down the row of PATTERN_MAX cells, one cell per cycle, and keeps item_ready
// low until that wave leaves the last cell.
// Output channel result_valid/result_ready: one transfer of matched per
// filename, set when the wave of its last byte leaves the last cell.
// A result waiting at the output does not block the input: a second result
// is parked in a skid register, and only then is item_ready held low.
// Registers over APB: include_mode at 0x0 (reset 1), pattern_length at 0x4
// (reset 0). Write them only while the block is idle.
// Reset clears the control state and the output; the pattern store holds
// garbage until written.
module filename_wildcard_filter import fwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              func,
	input  logic [IDX_W-1:0]  pattern_index,
	input  logic [7:0]        byte_value,
	input  logic              name_last,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              matched,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic                include_mode;
	logic [LEN_W-1:0]    pattern_length;
	logic [CNT_W-1:0]    eff_len;
	logic                accept;
	logic [7:0]          ch;
	logic                is_sep;
	logic                res;
	logic                busy_q;
	logic                at_start_q;
	logic                out_valid_q;
	logic                out_q;
	logic                skid_valid_q;
	logic                skid_q;
	wave_t               inj_q;
	wave_t               tok [PATTERN_MAX+1];
	cell_ctl_t           ctl [PATTERN_MAX];
	logic [PATTERN_MAX:0] space_v;

	fwf_apb u_apb (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.include_mode  (include_mode),
		.pattern_length(pattern_length)
	);

	assign eff_len = (32'(pattern_length) > PATTERN_MAX) ? CNT_W'(PATTERN_MAX)
		: CNT_W'(pattern_length);

	assign item_ready = !busy_q && !skid_valid_q;
	assign accept     = item_valid && item_ready;
	assign ch         = fold_byte(byte_value);
	assign is_sep     = (ch == CH_SLASH) || (ch == CH_BSLASH);

	assign tok[0]               = inj_q;
	assign space_v[PATTERN_MAX] = 1'b0;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		assign ctl[j].wr_en    = accept && (func == FUNC_PATTERN)
			&& (pattern_index == IDX_W'(j));
		assign ctl[j].in_len   = CNT_W'(j) < eff_len;
		assign ctl[j].last_pos = CNT_W'(j + 1) == eff_len;

		fwf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[j]),
			.wr_data    (byte_value),
			.right_space(space_v[j+1]),
			.tok_in     (tok[j]),
			.tok_out    (tok[j+1]),
			.is_space   (space_v[j])
		);
	end

	assign res = tok[PATTERN_MAX].hit ^ !include_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			at_start_q   <= 1'b1;
			inj_q        <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= 1'b0;
			skid_valid_q <= 1'b0;
			skid_q       <= 1'b0;
		end else begin
			inj_q.valid <= accept && (func == FUNC_NAME) && !(is_sep && !name_last);
			if (accept && func == FUNC_NAME) begin
				if (is_sep && !name_last) begin
					at_start_q <= 1'b1;
				end else begin
					inj_q.eval_empty <= is_sep;
					inj_q.at_start   <= is_sep || at_start_q;
					inj_q.want_hit   <= name_last;
					inj_q.ch         <= ch;
					inj_q.left_space <= 1'b1;
					inj_q.empty_left <= 1'b0;
					inj_q.prev_left  <= 1'b0;
					inj_q.new_left   <= 1'b0;
					inj_q.hit        <= 1'b0;
					busy_q           <= 1'b1;
					at_start_q       <= name_last;
				end
			end

			if (tok[PATTERN_MAX].valid) begin
				busy_q <= 1'b0;
			end

			if (tok[PATTERN_MAX].valid && tok[PATTERN_MAX].want_hit) begin
				if (out_valid_q && !result_ready) begin
					skid_q       <= res;
					skid_valid_q <= 1'b1;
				end else begin
					out_q       <= res;
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && result_ready) begin
				// output register drains, then the skid slot moves up
				if (skid_valid_q) begin
					out_q        <= skid_q;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign result_valid = out_valid_q;
	assign matched      = out_q;

endmodule

// File: rtl/fwf_checker.sv
module fwf_checker import fwf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       func,
	input logic [7:0] byte_value,
	input logic       name_last,
	input logic       result_valid,
	input logic       result_ready,
	input logic       matched
);

	logic take;
	logic sep;

	assign take = item_valid && item_ready;
	assign sep  = (byte_value == CH_SLASH) || (byte_value == CH_BSLASH);

	// a name byte that walks the cell row keeps the input closed
	a_wave_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && func == FUNC_NAME && !sep |=> !item_ready)
		else $error("input open while a wave is in flight");

	a_pattern_fast: assert property (@(posedge clk) disable iff (!arst_n)
		take && func == FUNC_PATTERN |=> item_ready)
		else $error("pattern write did not finish in one cycle");

	a_sep_fast: assert property (@(posedge clk) disable iff (!arst_n)
		take && func == FUNC_NAME && sep && !name_last |=> item_ready)
		else $error("separator did not finish in one cycle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(matched))
		else $error("stalled result changed or vanished");

endmodule

bind filename_wildcard_filter fwf_checker u_fwf_checker (.*);

// File: test/filename_wildcard_filter_checker.sv
`timescale 1ns / 100ps

module filename_wildcard_filter_checker import fwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  logic              func,
	input  logic [IDX_W-1:0]  pattern_index,
	input  logic [7:0]        byte_value,
	input  logic              name_last,
	input  logic              result_valid,
	input  logic              result_ready,
	input  logic              matched,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending
);

	logic [7:0]             pat_store [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] prefix_row;
	logic                   base_empty;
	logic                   include_on;
	logic [LEN_W-1:0]       stored_len;
	logic                   verdict_q[$];
	int                     fails = 0;
	int                     waiting = 0;
	int                     shown = 0;

	assign fail_count = fails;
	assign pending = waiting;

	function automatic int used_len();
		return (stored_len > PATTERN_MAX) ? PATTERN_MAX : int'(stored_len);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic opens_alt(input int j);
		return j == 0 || pat_store[j-1] == CH_SPACE;
	endfunction

	// prefix row as it stands before any byte of the base name
	function automatic logic [PATTERN_MAX-1:0] empty_name_row();
		logic [PATTERN_MAX-1:0] r;
		int                     j;
		r = '0;
		for (j = 0; j < used_len(); j++) begin
			if (pat_store[j] == CH_SPACE)
				r[j] = 1'b0;
			else if (opens_alt(j))
				r[j] = pat_store[j] == CH_STAR;
			else
				r[j] = r[j-1] && pat_store[j] == CH_STAR;
		end
		return r;
	endfunction

	function automatic logic any_alt_done(input logic [PATTERN_MAX-1:0] r);
		int n;
		int j;
		n = used_len();
		for (j = 0; j < n; j++) begin
			if (pat_store[j] != CH_SPACE && r[j] &&
			    (j + 1 == n || pat_store[j+1] == CH_SPACE))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void advance_name(input logic [7:0] c);
		logic [PATTERN_MAX-1:0] prev;
		logic [PATTERN_MAX-1:0] nxt;
		logic [7:0]             p;
		logic                   head;
		logic                   left_prev;
		logic                   left_new;
		int                     j;
		prev = base_empty ? empty_name_row() : prefix_row;
		nxt = '0;
		for (j = 0; j < used_len(); j++) begin
			p = to_lower(pat_store[j]);
			if (p != CH_SPACE) begin
				head = opens_alt(j);
				left_prev = head ? base_empty : prev[j-1];
				left_new = head ? 1'b0 : nxt[j-1];
				if (p == CH_STAR)
					nxt[j] = left_new || prev[j];
				else if (p == CH_QUES || p == c)
					nxt[j] = left_prev;
			end
		end
		prefix_row = nxt;
		base_empty = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pat_store[i])
				pat_store[i] = 8'h00;
			prefix_row = '0;
			base_empty = 1'b1;
			include_on = 1'b1;
			stored_len = '0;
			verdict_q.delete();
			waiting = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (verdict_q.size() == 0) begin
					fails++;
					if (shown < 10)
						$display("%0t: result transfer with none expected, matched %0b",
							$realtime, matched);
					shown++;
				end else if (matched !== verdict_q[0]) begin
					fails++;
					if (shown < 10)
						$display("%0t: matched mismatch, expected %0b got %0b",
							$realtime, verdict_q[0], matched);
					shown++;
					void'(verdict_q.pop_front());
				end else begin
					void'(verdict_q.pop_front());
				end
			end

			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_INCLUDE_MODE)
					include_on = pwdata[0];
				else if (paddr[2] == REG_PATTERN_LENGTH)
					stored_len = pwdata[LEN_W-1:0];
			end

			if (item_valid && item_ready) begin
				if (func == FUNC_PATTERN) begin
					pat_store[pattern_index] = byte_value;
				end else begin
					if (to_lower(byte_value) == CH_SLASH || to_lower(byte_value) == CH_BSLASH) begin
						prefix_row = '0;
						base_empty = 1'b1;
					end else begin
						advance_name(to_lower(byte_value));
					end
					if (name_last) begin
						verdict_q.push_back(
							any_alt_done(base_empty ? empty_name_row() : prefix_row) ==
							include_on);
						prefix_row = '0;
						base_empty = 1'b1;
					end
				end
			end
			waiting = verdict_q.size();
		end
	end

endmodule

// File: test/filename_wildcard_filter_tb.sv
`timescale 1ns / 100ps

module filename_wildcard_filter_tb import fwf_pkg::*;;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	logic              func;
	logic [IDX_W-1:0]  pattern_index;
	logic [7:0]        byte_value;
	logic              name_last;
	logic              result_valid;
	logic              result_ready;
	logic              matched;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	logic [7:0] pat_img [PATTERN_MAX];
	logic [7:0] name_buf[$];
	int         cur_len;
	int         item_total;
	logic       quiet;

	filename_wildcard_filter uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.func(func), .pattern_index(pattern_index), .byte_value(byte_value),
		.name_last(name_last),
		.result_valid(result_valid), .result_ready(result_ready), .matched(matched),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	filename_wildcard_filter_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.func(func), .pattern_index(pattern_index), .byte_value(byte_value),
		.name_last(name_last),
		.result_valid(result_valid), .result_ready(result_ready), .matched(matched),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	// result side back-pressure: short and long stalls, some long open stretches
	initial begin
		int   hold;
		int   r;
		logic lvl;
		result_ready = 1'b0;
		hold = 0;
		lvl = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					lvl = 1'b1;
					hold = $urandom_range(100, 300);
				end else if (r < 55) begin
					lvl = 1'b1;
					hold = $urandom_range(1, 6);
				end else if (r < 90) begin
					lvl = 1'b0;
					hold = $urandom_range(1, 3);
				end else begin
					lvl = 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
			hold--;
			result_ready <= lvl;
		end
	end

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			c = "a" + 8'($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				c = c - 8'd32;
		end else if (r < 60) begin
			c = ".";
		end else if (r < 70) begin
			c = "0" + 8'($urandom_range(0, 2));
		end else begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_SLASH || c == CH_BSLASH);
		end
		return c;
	endfunction

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return plain_char();
		if (r < 62)
			return CH_STAR;
		if (r < 74)
			return CH_QUES;
		if (r < 90)
			return CH_SPACE;
		return plain_char();
	endfunction

	function automatic void make_noise_name();
		int n;
		name_buf.delete();
		n = $urandom_range(1, 8);
		repeat (n)
			name_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	// expand one stored alternative into a name that it should match, at times with a byte changed or added
	function automatic void make_matching_name();
		int         starts[$];
		int         j;
		logic [7:0] p;
		name_buf.delete();
		for (j = 0; j < cur_len; j++)
			if (pat_img[j] != CH_SPACE && (j == 0 || pat_img[j-1] == CH_SPACE))
				starts.push_back(j);
		if (starts.size() == 0) begin
			make_noise_name();
			return;
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3))
				name_buf.push_back(plain_char());
			name_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
		end
		j = starts[$urandom_range(0, starts.size() - 1)];
		while (j < cur_len && pat_img[j] != CH_SPACE) begin
			p = pat_img[j];
			if (p == CH_STAR)
				repeat ($urandom_range(0, 3))
					name_buf.push_back(plain_char());
			else if (p == CH_QUES)
				name_buf.push_back(plain_char());
			else if (p >= "a" && p <= "z" && $urandom_range(0, 1))
				name_buf.push_back(p - 8'd32);
			else if (p >= "A" && p <= "Z" && $urandom_range(0, 1))
				name_buf.push_back(p + 8'd32);
			else
				name_buf.push_back(p);
			j++;
		end
		if (name_buf.size() > 0 && $urandom_range(0, 6) == 0)
			name_buf[$urandom_range(0, name_buf.size() - 1)] = plain_char();
		if ($urandom_range(0, 9) == 0)
			name_buf.push_back(plain_char());
		// an alternative of stars alone can expand to nothing: end on a separator
		if (name_buf.size() == 0) begin
			name_buf.push_back(plain_char());
			name_buf.push_back(CH_SLASH);
		end
	endfunction

	task automatic put_item(input logic f, input logic [IDX_W-1:0] idx,
		input logic [7:0] b, input logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		pattern_index <= idx;
		byte_value <= b;
		name_last <= last;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
		item_total++;
	endtask

	task automatic write_pat(input int idx, input logic [7:0] b);
		put_item(FUNC_PATTERN, IDX_W'(idx), b, 1'($urandom_range(0, 1)));
		pat_img[idx] = b;
	endtask

	task automatic load_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			write_pat(i, s[i]);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			put_item(FUNC_NAME, IDX_W'($urandom_range(0, 63)), s[i], i == s.len() - 1);
	endtask

	// occasionally rewrites a store byte in the middle of a name
	task automatic send_buf();
		int i;
		for (i = 0; i < name_buf.size(); i++) begin
			if (i > 0 && $urandom_range(0, 49) == 0)
				write_pat($urandom_range(0, 63), pattern_char());
			put_item(FUNC_NAME, IDX_W'($urandom_range(0, 63)), name_buf[i],
				i == name_buf.size() - 1);
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2 * PATTERN_MAX + 8) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_id, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_id, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic mode, input int len);
		settle();
		apb_write(REG_INCLUDE_MODE, (DATA_W'($urandom) << 1) | DATA_W'(mode));
		apb_write(REG_PATTERN_LENGTH, (DATA_W'($urandom) << LEN_W) | DATA_W'(len));
		cur_len = (len > PATTERN_MAX) ? PATTERN_MAX : len;
	endtask

	initial begin
		int   ph;
		int   k;
		int   n;
		int   r;
		int   len;
		logic mode;
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = FUNC_PATTERN;
		pattern_index = '0;
		byte_value = 8'h00;
		name_last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		item_total = 0;
		cur_len = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty alternative between the double spaces, mixed case
		load_text("*.txt a?C **  B*");
		set_regs(1'b1, 16);
		send_text("a.TXT");
		send_text("AbC");
		send_text("dir\\sub/B");
		send_text("x/");
		send_text("abcd");
		put_item(FUNC_NAME, '1, 8'h00, 1'b1);
		put_item(FUNC_NAME, '0, 8'hFF, 1'b1);
		// store byte changes while a name is in flight
		put_item(FUNC_NAME, '0, "a", 1'b0);
		put_item(FUNC_NAME, '0, "b", 1'b0);
		write_pat(8, CH_QUES);
		put_item(FUNC_NAME, '0, "z", 1'b1);
		write_pat(8, "C");
		send_text("Q");
		set_regs(1'b0, 0);
		send_text("q");
		send_text("/");

		for (ph = 0; item_total < 1600; ph++) begin
			mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0: len = 0;
				1: len = 1;
				2: len = PATTERN_MAX;
				3: len = $urandom_range(PATTERN_MAX + 1, 127);
				default: len = $urandom_range(2, 24);
			endcase
			if (ph == 0) begin
				len = 127;
				mode = 1'b0;
			end else if (ph == 1) begin
				len = PATTERN_MAX;
				mode = 1'b1;
			end
			set_regs(mode, len);
			quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < cur_len; k++)
				write_pat(k, pattern_char());
			n = $urandom_range(15, 40);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 72) begin
					make_matching_name();
					send_buf();
				end else if (r < 84) begin
					make_noise_name();
					send_buf();
				end else if (r < 92) begin
					write_pat($urandom_range(0, 63), pattern_char());
				end else begin
					name_buf.delete();
					if ($urandom_range(0, 1))
						name_buf.push_back(plain_char());
					name_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
					send_buf();
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
